### hw/rtl/orthant_nt_scaling_update_assert.svh
// ============================================================================
// Assertion macros for the orthant scaling update
// Shared concurrent assertion forms, clocked on i_clk.
// ============================================================================
`ifndef ORTHANT_NT_SCALING_UPDATE_ASSERT_SVH
`define ORTHANT_NT_SCALING_UPDATE_ASSERT_SVH

// Same-cycle implication, off while reset is asserted
`define ONS_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, active through reset
`define ONS_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) (ante) |=> (cons)) else $error(msg);

`endif

### hw/rtl/ons_pkg.sv
// ============================================================================
// ons_pkg
// Shared types for the orthant scaling update.
// ============================================================================
`timescale 1ns / 1ps

package ons_pkg;

    // Result status codes
    typedef enum logic [1:0] {
        STATUS_OK         = 2'd0,
        STATUS_DUAL_ZERO  = 2'd1,
        STATUS_SCALE_ZERO = 2'd2
    } t_status;

endpackage

### hw/rtl/ons_sqrt_pipe.sv
// ============================================================================
// ons_sqrt_pipe
// Pipelined integer square root, one root bit per register stage.
// ============================================================================
`timescale 1ns / 1ps

module ons_sqrt_pipe #(
    parameter int IN_BITS   = 48,
    parameter int SIDE_BITS = 1,
    parameter int ROOT_BITS = (IN_BITS + 1) / 2
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    input  logic [IN_BITS-1:0]   i_radicand,
    input  logic [SIDE_BITS-1:0] i_side,
    output logic                 o_valid,
    output logic [ROOT_BITS-1:0] o_root,
    output logic [SIDE_BITS-1:0] o_side
);

    localparam int PAD_BITS = 2 * ROOT_BITS;
    localparam int REM_BITS = ROOT_BITS + 3;

    logic [PAD_BITS-1:0]  r_rad   [1:ROOT_BITS];
    logic [ROOT_BITS-1:0] r_root  [1:ROOT_BITS];
    logic [REM_BITS-1:0]  r_rem   [1:ROOT_BITS];
    logic [SIDE_BITS-1:0] r_side  [1:ROOT_BITS];
    logic [ROOT_BITS:1]   r_valid;

    for (genvar k = 0; k < ROOT_BITS; k++) begin : g_stage
        logic [PAD_BITS-1:0]  c_rad;
        logic [ROOT_BITS-1:0] c_root;
        logic [REM_BITS-1:0]  c_rem;
        logic [SIDE_BITS-1:0] c_side;
        logic                 c_valid;
        logic [REM_BITS-1:0]  t_rem;
        logic [REM_BITS-1:0]  t_trial;
        logic                 t_ge;

        // Pick the stage inputs
        if (k == 0) begin : g_first
            assign c_rad   = PAD_BITS'(i_radicand);
            assign c_root  = '0;
            assign c_rem   = '0;
            assign c_side  = i_side;
            assign c_valid = i_valid;
        end else begin : g_next
            assign c_rad   = r_rad[k];
            assign c_root  = r_root[k];
            assign c_rem   = r_rem[k];
            assign c_side  = r_side[k];
            assign c_valid = r_valid[k];
        end

        // Bring down two bits and try the next root bit
        assign t_rem   = {c_rem[REM_BITS-3:0], c_rad[PAD_BITS-1 -: 2]};
        assign t_trial = REM_BITS'({c_root, 2'b01});
        assign t_ge    = (t_rem >= t_trial);

        // Advance payload
        always_ff @(posedge i_clk) begin
            r_rad[k+1]  <= c_rad << 2;
            r_root[k+1] <= {c_root[ROOT_BITS-2:0], t_ge};
            r_rem[k+1]  <= t_ge ? (t_rem - t_trial) : t_rem;
            r_side[k+1] <= c_side;
        end

        // Advance valid
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_valid[k+1] <= 1'b0;
            end else begin
                r_valid[k+1] <= c_valid;
            end
        end
    end

    assign o_valid = r_valid[ROOT_BITS];
    assign o_root  = r_root[ROOT_BITS];
    assign o_side  = r_side[ROOT_BITS];

endmodule

### hw/rtl/ons_div_pipe.sv
// ============================================================================
// ons_div_pipe
// Pipelined restoring divider with a saturated quotient, one bit per stage.
// ============================================================================
`timescale 1ns / 1ps

module ons_div_pipe #(
    parameter int NUM_BITS  = 56,
    parameter int DEN_BITS  = 24,
    parameter int Q_BITS    = 32,
    parameter int SIDE_BITS = 1
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    input  logic [NUM_BITS-1:0]  i_num,
    input  logic [DEN_BITS-1:0]  i_den,
    input  logic [SIDE_BITS-1:0] i_side,
    output logic                 o_valid,
    output logic [Q_BITS-1:0]    o_quot,
    output logic [SIDE_BITS-1:0] o_side
);

    localparam int HI_BITS  = NUM_BITS - Q_BITS;
    localparam int CMP_BITS = (HI_BITS > DEN_BITS) ? HI_BITS : DEN_BITS;

    logic [DEN_BITS-1:0]  r_rem   [0:Q_BITS];
    logic [Q_BITS-1:0]    r_low   [0:Q_BITS];
    logic [Q_BITS-1:0]    r_quot  [0:Q_BITS];
    logic [DEN_BITS-1:0]  r_den   [0:Q_BITS];
    logic [SIDE_BITS-1:0] r_side  [0:Q_BITS];
    logic [Q_BITS:0]      r_ovf;
    logic [Q_BITS:0]      r_valid;

    logic [HI_BITS-1:0] w_hi;

    // Entry: quotient overflows the word when the upper part reaches den
    assign w_hi = i_num[NUM_BITS-1:Q_BITS];

    always_ff @(posedge i_clk) begin
        r_rem[0]  <= DEN_BITS'(w_hi);
        r_low[0]  <= i_num[Q_BITS-1:0];
        r_quot[0] <= '0;
        r_den[0]  <= i_den;
        r_side[0] <= i_side;
        r_ovf[0]  <= (CMP_BITS'(w_hi) >= CMP_BITS'(i_den));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid[0] <= 1'b0;
        end else begin
            r_valid[0] <= i_valid;
        end
    end

    for (genvar k = 0; k < Q_BITS; k++) begin : g_stage
        logic [DEN_BITS:0] t_rem;
        logic              t_ge;

        // Shift in the next numerator bit and trial subtract
        assign t_rem = {r_rem[k], r_low[k][Q_BITS-1]};
        assign t_ge  = (t_rem >= {1'b0, r_den[k]});

        always_ff @(posedge i_clk) begin
            r_rem[k+1]  <= t_ge ? DEN_BITS'(t_rem - {1'b0, r_den[k]})
                                : DEN_BITS'(t_rem);
            r_low[k+1]  <= r_low[k] << 1;
            r_quot[k+1] <= {r_quot[k][Q_BITS-2:0], t_ge};
            r_den[k+1]  <= r_den[k];
            r_side[k+1] <= r_side[k];
            r_ovf[k+1]  <= r_ovf[k];
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_valid[k+1] <= 1'b0;
            end else begin
                r_valid[k+1] <= r_valid[k];
            end
        end
    end

    // Saturate on overflow
    assign o_valid = r_valid[Q_BITS];
    assign o_quot  = r_ovf[Q_BITS] ? '1 : r_quot[Q_BITS];
    assign o_side  = r_side[Q_BITS];

endmodule

### hw/rtl/orthant_nt_scaling_update.sv
// ============================================================================
// orthant_nt_scaling_update
// Nesterov-Todd scaling update for the nonnegative orthant, one element per
// request: square roots, scaled quotient, reciprocal and scaled point.
// ============================================================================
//
//  channel  | handshake            | fields
//  ---------+----------------------+------------------------------------------
//  request  | start in, busy out   | i_old_scale, i_slack_value, i_dual_value
//  result   | o_done strobe (out)  | o_new_scale, o_inverse_scale,
//           |                      | o_scaled_point, o_status
//
//  A request is taken every cycle; busy is always low.
//  A result passes the bit-serial root stages, one per bit of the root,
//  ROOT_BITS = (WORD_BITS + FRAC_BITS + 1) / 2, then the multiply register,
//  the two divider pipelines (an entry register plus one bit per stage each)
//  and the output register.
//  Synchronous active-low reset clears all valid bits; payload is not reset.
//  The receiver cannot stall: each result shows for one cycle with o_done.
//
`timescale 1ns / 1ps
`include "orthant_nt_scaling_update_assert.svh"

module orthant_nt_scaling_update #(
    parameter int WORD_BITS = 32,
    parameter int FRAC_BITS = 16
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 start,
    output logic                 busy,
    input  logic [WORD_BITS-1:0] i_old_scale,
    input  logic [WORD_BITS-1:0] i_slack_value,
    input  logic [WORD_BITS-1:0] i_dual_value,
    output logic                 o_done,
    output logic [WORD_BITS-1:0] o_new_scale,
    output logic [WORD_BITS-1:0] o_inverse_scale,
    output logic [WORD_BITS-1:0] o_scaled_point,
    output logic [1:0]           o_status
);

    localparam int RAD_BITS   = WORD_BITS + FRAC_BITS;
    localparam int ROOT_BITS  = (RAD_BITS + 1) / 2;
    localparam int PROD_BITS  = WORD_BITS + ROOT_BITS;
    localparam int ONE2_BITS  = 2 * FRAC_BITS + 1;
    localparam int RECIP_BITS = (ONE2_BITS > WORD_BITS + 1) ? ONE2_BITS : WORD_BITS + 1;
    localparam int SIDE2_BITS = 2 * WORD_BITS + 2;

    // Square root stage outputs
    logic                 w_rs_valid;
    logic                 w_rz_valid;
    logic [ROOT_BITS-1:0] w_rs;
    logic [ROOT_BITS-1:0] w_rz;
    logic [WORD_BITS-1:0] w_rs_d;
    logic                 w_rz_zero;

    // Multiply stage
    logic [2*ROOT_BITS-1:0] w_pt_full;
    logic [2*ROOT_BITS-1:0] w_pt_shift;
    logic                   r_m_valid;
    logic [PROD_BITS-1:0]   r_m_prod;
    logic [ROOT_BITS-1:0]   r_m_rz;
    logic [WORD_BITS-1:0]   r_m_point;
    logic                   r_m_zz;

    // Divider outputs
    logic                  w_d1_valid;
    logic [WORD_BITS-1:0]  w_d1_scale;
    logic [WORD_BITS:0]    w_d1_side;
    ons_pkg::t_status      w_status;
    logic                  w_d2_valid;
    logic [WORD_BITS-1:0]  w_d2_inv;
    logic [SIDE2_BITS-1:0] w_d2_side;

    // Output register
    logic                 r_done;
    logic [WORD_BITS-1:0] r_new_scale;
    logic [WORD_BITS-1:0] r_inverse_scale;
    logic [WORD_BITS-1:0] r_scaled_point;
    logic [1:0]           r_status;

    assign busy = 1'b0;

    // Roots of s and z, scaled by the fraction
    ons_sqrt_pipe #(
        .IN_BITS   (RAD_BITS),
        .SIDE_BITS (WORD_BITS),
        .ROOT_BITS (ROOT_BITS)
    ) u_sqrt_s (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (start),
        .i_radicand ({i_slack_value, FRAC_BITS'(0)}),
        .i_side     (i_old_scale),
        .o_valid    (w_rs_valid),
        .o_root     (w_rs),
        .o_side     (w_rs_d)
    );

    ons_sqrt_pipe #(
        .IN_BITS   (RAD_BITS),
        .SIDE_BITS (1),
        .ROOT_BITS (ROOT_BITS)
    ) u_sqrt_z (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (start),
        .i_radicand ({i_dual_value, FRAC_BITS'(0)}),
        .i_side     (i_dual_value == '0),
        .o_valid    (w_rz_valid),
        .o_root     (w_rz),
        .o_side     (w_rz_zero)
    );

    // Form d*sqrt(s) and the saturated scaled point
    assign w_pt_full  = (2*ROOT_BITS)'(w_rs) * (2*ROOT_BITS)'(w_rz);
    assign w_pt_shift = w_pt_full >> FRAC_BITS;

    always_ff @(posedge i_clk) begin
        r_m_prod  <= PROD_BITS'(w_rs_d) * PROD_BITS'(w_rs);
        r_m_rz    <= w_rz;
        r_m_zz    <= w_rz_zero;
        r_m_point <= ((w_pt_shift >> WORD_BITS) != '0) ? '1
                                                       : w_pt_shift[WORD_BITS-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_valid <= 1'b0;
        end else begin
            r_m_valid <= w_rs_valid && w_rz_valid;
        end
    end

    // New scaling; a zero divisor saturates to all ones
    ons_div_pipe #(
        .NUM_BITS  (PROD_BITS),
        .DEN_BITS  (ROOT_BITS),
        .Q_BITS    (WORD_BITS),
        .SIDE_BITS (WORD_BITS + 1)
    ) u_div_scale (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r_m_valid),
        .i_num   (r_m_prod),
        .i_den   (r_m_rz),
        .i_side  ({r_m_point, r_m_zz}),
        .o_valid (w_d1_valid),
        .o_quot  (w_d1_scale),
        .o_side  (w_d1_side)
    );

    // Classify the result
    always_comb begin
        if (w_d1_side[0]) begin
            w_status = ons_pkg::STATUS_DUAL_ZERO;
        end else if (w_d1_scale == '0) begin
            w_status = ons_pkg::STATUS_SCALE_ZERO;
        end else begin
            w_status = ons_pkg::STATUS_OK;
        end
    end

    // Reciprocal 1.0 / scale; a zero scale saturates to all ones
    ons_div_pipe #(
        .NUM_BITS  (RECIP_BITS),
        .DEN_BITS  (WORD_BITS),
        .Q_BITS    (WORD_BITS),
        .SIDE_BITS (SIDE2_BITS)
    ) u_div_recip (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_d1_valid),
        .i_num   (RECIP_BITS'(1) << (2 * FRAC_BITS)),
        .i_den   (w_d1_scale),
        .i_side  ({w_d1_scale, w_d1_side[WORD_BITS:1], w_status}),
        .o_valid (w_d2_valid),
        .o_quot  (w_d2_inv),
        .o_side  (w_d2_side)
    );

    // Register the result
    always_ff @(posedge i_clk) begin
        r_new_scale     <= w_d2_side[SIDE2_BITS-1 -: WORD_BITS];
        r_scaled_point  <= w_d2_side[WORD_BITS+1:2];
        r_status        <= w_d2_side[1:0];
        r_inverse_scale <= w_d2_inv;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_done <= 1'b0;
        end else begin
            r_done <= w_d2_valid;
        end
    end

    assign o_done          = r_done;
    assign o_new_scale     = r_new_scale;
    assign o_inverse_scale = r_inverse_scale;
    assign o_scaled_point  = r_scaled_point;
    assign o_status        = r_status;

    `ONS_ASSERT_NEXT(a_reset_no_done, !i_rst_n, !o_done, "result strobe after reset")
    `ONS_ASSERT_NOW(a_dual_zero, o_done && (o_status == ons_pkg::STATUS_DUAL_ZERO), (o_new_scale == '1) && (o_scaled_point == '0), "dual zero result wrong")
    `ONS_ASSERT_NOW(a_scale_zero, o_done && (o_status == ons_pkg::STATUS_SCALE_ZERO), (o_new_scale == '0) && (o_inverse_scale == '1), "zero scale result wrong")
    `ONS_ASSERT_NOW(a_zero_flagged, o_done && (o_new_scale == '0), o_status == ons_pkg::STATUS_SCALE_ZERO, "zero scale not flagged")

endmodule

### verif/tb_orthant_nt_scaling_update.sv
`timescale 1ns / 1ps
// ============================================================================
// tb_orthant_nt_scaling_update
// Self-checking bench for the orthant scaling update. A table of directed
// requests (extremes, zero dual, zero scaling, unit values) runs first, then
// random requests in bursts. Expectations come from the typed rows or exact
// wide integer arithmetic and are compared with the strobed results, in order.
// ============================================================================

module tb_orthant_nt_scaling_update;

    localparam int WB       = 32;
    localparam int FB       = 16;
    localparam int N_RANDOM = 1850;
    localparam int WD_LIMIT = 2000;
    localparam logic [WB-1:0] ONES = {WB{1'b1}};
    localparam logic [WB-1:0] UNIT = 32'h0001_0000;

    typedef struct {
        logic [WB-1:0]    d;
        logic [WB-1:0]    s;
        logic [WB-1:0]    z;
        bit               typed;
        logic [WB-1:0]    scale;
        logic [WB-1:0]    inv;
        logic [WB-1:0]    point;
        ons_pkg::t_status status;
    } t_request;

    typedef struct {
        logic [WB-1:0]    scale;
        logic [WB-1:0]    inv;
        logic [WB-1:0]    point;
        ons_pkg::t_status status;
    } t_update;

    logic          i_clk;
    logic          i_rst_n;
    logic          start;
    logic          busy;
    logic [WB-1:0] i_old_scale;
    logic [WB-1:0] i_slack_value;
    logic [WB-1:0] i_dual_value;
    logic          o_done;
    logic [WB-1:0] o_new_scale;
    logic [WB-1:0] o_inverse_scale;
    logic [WB-1:0] o_scaled_point;
    logic [1:0]    o_status;

    t_request directed[$];
    t_update  pending_updates[$];
    int       n_errors;
    int       idle_cycles;

    orthant_nt_scaling_update uut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .start           (start),
        .busy            (busy),
        .i_old_scale     (i_old_scale),
        .i_slack_value   (i_slack_value),
        .i_dual_value    (i_dual_value),
        .o_done          (o_done),
        .o_new_scale     (o_new_scale),
        .o_inverse_scale (o_inverse_scale),
        .o_scaled_point  (o_scaled_point),
        .o_status        (o_status)
    );

    // Clock: 2 ns period
    always begin
        i_clk = 1'b1;
        #1;
        i_clk = 1'b0;
        #1;
    end

    // Integer square root, floor
    function automatic logic [63:0] int_root(input logic [63:0] v);
        logic [63:0] rem;
        logic [63:0] res;
        logic [63:0] bitv;
        rem  = v;
        res  = '0;
        bitv = 64'd1 << 62;
        for (int i = 0; i < 32; i++) begin
            if (rem >= res + bitv) begin
                rem = rem - (res + bitv);
                res = (res >> 1) + bitv;
            end else begin
                res = res >> 1;
            end
            bitv = bitv >> 2;
        end
        return res;
    endfunction

    // Clamp a wide value to the word range
    function automatic logic [WB-1:0] clamp_word(input logic [127:0] v);
        return (v > {96'd0, ONES}) ? ONES : v[WB-1:0];
    endfunction

    // Compute the expected scaling update for one request
    function automatic t_update scaling_update(input logic [WB-1:0] d,
                                               input logic [WB-1:0] s,
                                               input logic [WB-1:0] z);
        t_update      u;
        logic [63:0]  rs;
        logic [63:0]  rz;
        logic [127:0] num;
        rs = int_root({32'd0, s} << FB);
        rz = int_root({32'd0, z} << FB);
        u.status = ons_pkg::STATUS_OK;
        if (rz == 0) begin
            u.scale  = ONES;
            u.status = ons_pkg::STATUS_DUAL_ZERO;
        end else begin
            num     = {96'd0, d} * {64'd0, rs};
            u.scale = clamp_word(num / {64'd0, rz});
            if (u.scale == 0) u.status = ons_pkg::STATUS_SCALE_ZERO;
        end
        if (u.scale == 0) begin
            u.inv = ONES;
        end else begin
            u.inv = clamp_word((128'd1 << (2 * FB)) / {96'd0, u.scale});
        end
        u.point = clamp_word(({64'd0, rs} * {64'd0, rz}) >> FB);
        return u;
    endfunction

    function automatic logic [WB-1:0] rand_field();
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return ONES;
            2:       return $urandom_range(0, 16'hFFFF);
            3, 4:    return UNIT - 32'd2048 + $urandom_range(0, 4095);
            5:       return $urandom_range(1, 8);
            default: return $urandom;
        endcase
    endfunction

    task automatic add_row(input logic [WB-1:0] d, input logic [WB-1:0] s,
                           input logic [WB-1:0] z, input bit typed,
                           input logic [WB-1:0] scale, input logic [WB-1:0] inv,
                           input logic [WB-1:0] point, input ons_pkg::t_status status);
        t_request r;
        r.d = d; r.s = s; r.z = z; r.typed = typed;
        r.scale = scale; r.inv = inv; r.point = point; r.status = status;
        directed.push_back(r);
    endtask

    task automatic report(input string what, input logic [WB-1:0] got,
                          input logic [WB-1:0] want);
        $display("mismatch %s: got %h, want %h at %0t", what, got, want, $realtime);
        n_errors++;
    endtask

    // Check each strobed result against the oldest expectation
    always @(posedge i_clk) begin
        t_update w;
        if (i_rst_n && o_done) begin
            if (pending_updates.size() == 0) begin
                report("unexpected result", o_new_scale, '0);
            end else begin
                w = pending_updates.pop_front();
                if (o_new_scale !== w.scale) report("new_scale", o_new_scale, w.scale);
                if (o_inverse_scale !== w.inv)
                    report("inverse_scale", o_inverse_scale, w.inv);
                if (o_scaled_point !== w.point)
                    report("scaled_point", o_scaled_point, w.point);
                if (o_status !== w.status)
                    report("status", {30'd0, o_status}, {30'd0, w.status});
            end
        end
    end

    // Watchdog: end the run when nothing moves for too long
    always @(posedge i_clk) begin
        if (!i_rst_n || (start && !busy) || o_done) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WD_LIMIT) begin
            $display("tb_orthant_nt_scaling_update failed");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        t_request r;
        t_update  w;
        int       total;
        int       sent;
        int       burst_left;
        int       gap_left;
        bit       drained;

        n_errors      = 0;
        i_rst_n       = 1'b0;
        start         = 1'b0;
        i_old_scale   = '0;
        i_slack_value = '0;
        i_dual_value  = '0;

        // Directed rows: zero dual wins over everything, zero scaling, extremes
        add_row(UNIT, UNIT, UNIT, 1'b1, UNIT, UNIT, UNIT, ons_pkg::STATUS_OK);
        add_row('0, '0, '0, 1'b1, ONES, 32'd1, '0, ons_pkg::STATUS_DUAL_ZERO);
        add_row(ONES, ONES, '0, 1'b1, ONES, 32'd1, '0, ons_pkg::STATUS_DUAL_ZERO);
        add_row(UNIT, UNIT, '0, 1'b1, ONES, 32'd1, '0, ons_pkg::STATUS_DUAL_ZERO);
        add_row('0, UNIT, UNIT, 1'b1, '0, ONES, UNIT, ons_pkg::STATUS_SCALE_ZERO);
        add_row(UNIT, '0, UNIT, 1'b1, '0, ONES, '0, ons_pkg::STATUS_SCALE_ZERO);
        add_row('0, '0, ONES, 1'b1, '0, ONES, '0, ons_pkg::STATUS_SCALE_ZERO);
        add_row(32'd1, 32'd1, ONES, 1'b0, '0, '0, '0, ons_pkg::STATUS_OK);
        add_row(ONES, ONES, ONES, 1'b0, '0, '0, '0, ons_pkg::STATUS_OK);
        add_row(ONES, ONES, 32'd1, 1'b0, '0, '0, '0, ons_pkg::STATUS_OK);
        add_row(32'd1, 32'd1, 32'd1, 1'b0, '0, '0, '0, ons_pkg::STATUS_OK);
        add_row(ONES, 32'd1, ONES, 1'b0, '0, '0, '0, ons_pkg::STATUS_OK);
        add_row(32'h8000_0000, 32'h0004_0000, UNIT, 1'b0, '0, '0, '0,
                ons_pkg::STATUS_OK);
        add_row(32'd3, UNIT, 32'h0009_0000, 1'b0, '0, '0, '0, ons_pkg::STATUS_OK);
        add_row(32'hAAAA_AAAA, 32'h5555_5555, 32'hAAAA_AAAA, 1'b0, '0, '0, '0,
                ons_pkg::STATUS_OK);
        add_row(32'h5555_5555, 32'hAAAA_AAAA, 32'h5555_5555, 1'b0, '0, '0, '0,
                ons_pkg::STATUS_OK);
        add_row(UNIT, 32'd1, 32'd1, 1'b0, '0, '0, '0, ons_pkg::STATUS_OK);

        total      = directed.size() + N_RANDOM;
        sent       = 0;
        burst_left = 0;
        gap_left   = 0;
        drained    = 1'b0;

        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (sent < total) begin
            @(posedge i_clk);
            // Take the request accepted at this edge
            if (start && !busy) begin
                if (sent < directed.size() && directed[sent].typed) begin
                    w.scale  = directed[sent].scale;
                    w.inv    = directed[sent].inv;
                    w.point  = directed[sent].point;
                    w.status = directed[sent].status;
                end else begin
                    w = scaling_update(i_old_scale, i_slack_value, i_dual_value);
                end
                pending_updates.push_back(w);
                sent++;
            end
            // Hold off once after the directed part until all results return
            if (sent == directed.size() && !drained) begin
                drained = 1'b1;
                start <= 1'b0;
                while (pending_updates.size() != 0) @(posedge i_clk);
                continue;
            end
            // Drive the next request, in bursts with random gaps
            if (sent >= total) begin
                start <= 1'b0;
            end else if (gap_left > 0) begin
                gap_left--;
                start <= 1'b0;
            end else begin
                if (sent < directed.size()) begin
                    r = directed[sent];
                end else begin
                    r.d = rand_field();
                    r.s = rand_field();
                    r.z = rand_field();
                end
                i_old_scale   <= r.d;
                i_slack_value <= r.s;
                i_dual_value  <= r.z;
                start         <= 1'b1;
                if (burst_left > 0) burst_left--;
                if (burst_left == 0) begin
                    burst_left = $urandom_range(1, 40);
                    gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
                end
            end
        end

        // Drain, then let the pipeline settle
        while (pending_updates.size() != 0) @(posedge i_clk);
        repeat (120) @(posedge i_clk);

        if (n_errors == 0) begin
            $display("tb_orthant_nt_scaling_update passed");
        end else begin
            $display("tb_orthant_nt_scaling_update failed");
        end
        $finish;
    end

endmodule

### filelist.f
+incdir+hw/rtl
hw/rtl/ons_pkg.sv
hw/rtl/ons_sqrt_pipe.sv
hw/rtl/ons_div_pipe.sv
hw/rtl/orthant_nt_scaling_update.sv
verif/tb_orthant_nt_scaling_update.sv
